// ===== hdl/gzhp_pkg.sv =====
package gzhp_pkg;

    localparam int COUNT_BITS = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int TAIL_DEPTH = 8;
    localparam int TAIL_IDX_BITS = $clog2(TAIL_DEPTH);
    localparam int FILL_BITS = $clog2(TAIL_DEPTH + 1);

    localparam logic [7:0] MAGIC_0 = 8'h1f;
    localparam logic [7:0] MAGIC_1 = 8'h8b;
    localparam logic [7:0] METHOD_DEFLATE = 8'h08;
    localparam logic [7:0] FLG_EXTRA = 8'h04;
    localparam logic [7:0] FLG_NAME = 8'h08;
    localparam logic [7:0] FLG_COMMENT = 8'h10;
    localparam logic [7:0] FLG_HCRC = 8'h02;
    localparam logic [4:0] MIN_FILE_BYTES = 5'd18;
    localparam logic [3:0] FIXED_LAST_POS = 4'd9;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_SHORT = 3'd1;
    localparam logic [2:0] ST_BAD_MAGIC = 3'd2;
    localparam logic [2:0] ST_TRUNCATED = 3'd3;
    localparam logic [2:0] ST_NOT_DEFLATE = 3'd4;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [2:0] {
        PH_FIXED,
        PH_XLEN,
        PH_XDATA,
        PH_NAME,
        PH_COMMENT,
        PH_HCRC,
        PH_BODY,
        PH_REJECT
    } phase_t;

    typedef struct packed {
        logic [15:0] header_crc;
        logic [15:0] extra_length;
        logic [31:0] payload_length;
        logic [31:0] input_size;
        logic [31:0] data_crc;
        logic [7:0]  method_code;
        logic [7:0]  header_flags;
        logic [2:0]  status;
    } summary_t;

    typedef struct packed {
        logic       has_payload;
        logic [7:0] payload_byte;
        logic       has_summary;
        summary_t   summary;
    } entry_t;

    // next optional header section after the given one, in file order
    function automatic phase_t next_stage(input phase_t from, input logic [7:0] flags);
        phase_t res;
        res = PH_BODY;
        if (from < PH_HCRC && (flags & FLG_HCRC) != 8'h00) res = PH_HCRC;
        if (from < PH_COMMENT && (flags & FLG_COMMENT) != 8'h00) res = PH_COMMENT;
        if (from < PH_NAME && (flags & FLG_NAME) != 8'h00) res = PH_NAME;
        if (from < PH_XLEN && (flags & FLG_EXTRA) != 8'h00) res = PH_XLEN;
        return res;
    endfunction

endpackage

// ===== hdl/gzhp_front.sv =====
module gzhp_front #(
    parameter int COUNT_BITS = gzhp_pkg::COUNT_BITS
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             accept,
    input  logic [7:0]       data_byte,
    input  logic             final_byte,
    output logic             push,
    output gzhp_pkg::entry_t push_entry
);

    gzhp_pkg::phase_t phase_reg, phase_next;
    logic [3:0]  hpos_reg, hpos_next;
    logic        magic_reg, magic_next;
    logic [7:0]  method_reg, method_next;
    logic [7:0]  flags_reg, flags_next;
    logic [15:0] xtotal_reg, xtotal_next;
    logic [15:0] xleft_reg, xleft_next;
    logic [15:0] hcheck_reg, hcheck_next;
    logic [7:0]  tail_reg [gzhp_pkg::TAIL_DEPTH];
    logic [7:0]  tail_next [gzhp_pkg::TAIL_DEPTH];
    logic [gzhp_pkg::FILL_BITS-1:0] fill_reg, fill_next;
    logic [4:0]  total_reg, total_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [63:0] count_ext;
    logic        has_pay;
    logic [7:0]  pay_byte;
    gzhp_pkg::summary_t sum;

    always_comb begin
        phase_next  = phase_reg;
        hpos_next   = hpos_reg;
        magic_next  = magic_reg;
        method_next = method_reg;
        flags_next  = flags_reg;
        xtotal_next = xtotal_reg;
        xleft_next  = xleft_reg;
        hcheck_next = hcheck_reg;
        tail_next   = tail_reg;
        fill_next   = fill_reg;
        count_next  = count_reg;
        has_pay     = 1'b0;
        pay_byte    = tail_reg[0];
        sum         = '0;

        total_next = (total_reg < gzhp_pkg::MIN_FILE_BYTES) ? total_reg + 5'd1 : total_reg;

        case (phase_reg)
            gzhp_pkg::PH_FIXED: begin
                if ((hpos_reg == 4'd0 && data_byte != gzhp_pkg::MAGIC_0) ||
                    (hpos_reg == 4'd1 && data_byte != gzhp_pkg::MAGIC_1)) begin
                    magic_next = 1'b0;
                    phase_next = gzhp_pkg::PH_REJECT;
                end else begin
                    if (hpos_reg == 4'd2) method_next = data_byte;
                    if (hpos_reg == 4'd3) flags_next = data_byte;
                    if (hpos_reg >= gzhp_pkg::FIXED_LAST_POS) begin
                        hpos_next  = 4'd0;
                        phase_next = gzhp_pkg::next_stage(gzhp_pkg::PH_FIXED, flags_reg);
                    end else begin
                        hpos_next = hpos_reg + 4'd1;
                    end
                end
            end
            gzhp_pkg::PH_XLEN: begin
                if (hpos_reg == 4'd0) begin
                    xleft_next = {8'h00, data_byte};
                    hpos_next  = 4'd1;
                end else begin
                    xtotal_next = {data_byte, xleft_reg[7:0]};
                    xleft_next  = {data_byte, xleft_reg[7:0]};
                    hpos_next   = 4'd0;
                    phase_next  = ({data_byte, xleft_reg[7:0]} != 16'h0000) ?
                                  gzhp_pkg::PH_XDATA :
                                  gzhp_pkg::next_stage(gzhp_pkg::PH_XDATA, flags_reg);
                end
            end
            gzhp_pkg::PH_XDATA: begin
                xleft_next = xleft_reg - 16'd1;
                if (xleft_reg == 16'd1)
                    phase_next = gzhp_pkg::next_stage(gzhp_pkg::PH_XDATA, flags_reg);
            end
            gzhp_pkg::PH_NAME, gzhp_pkg::PH_COMMENT: begin
                if (data_byte == 8'h00) phase_next = gzhp_pkg::next_stage(phase_reg, flags_reg);
            end
            gzhp_pkg::PH_HCRC: begin
                if (hpos_reg == 4'd0) begin
                    xleft_next = {8'h00, data_byte};
                    hpos_next  = 4'd1;
                end else begin
                    hcheck_next = {data_byte, xleft_reg[7:0]};
                    hpos_next   = 4'd0;
                    phase_next  = gzhp_pkg::PH_BODY;
                end
            end
            gzhp_pkg::PH_BODY: begin
                if (fill_reg >= gzhp_pkg::FILL_BITS'(gzhp_pkg::TAIL_DEPTH)) begin
                    // delay line full: oldest byte is payload
                    for (int i = 0; i < gzhp_pkg::TAIL_DEPTH - 1; i++)
                        tail_next[i] = tail_reg[i+1];
                    tail_next[gzhp_pkg::TAIL_DEPTH-1] = data_byte;
                    if (count_reg != '1) count_next = count_reg + COUNT_BITS'(1);
                    has_pay = 1'b1;
                end else begin
                    tail_next[fill_reg[gzhp_pkg::TAIL_IDX_BITS-1:0]] = data_byte;
                    fill_next = fill_reg + gzhp_pkg::FILL_BITS'(1);
                end
            end
            default: begin
            end
        endcase

        count_ext = 64'(count_next);
        if (total_next < gzhp_pkg::MIN_FILE_BYTES) begin
            sum.status = gzhp_pkg::ST_SHORT;
        end else if (!magic_next) begin
            sum.status = gzhp_pkg::ST_BAD_MAGIC;
        end else begin
            sum.header_flags = flags_next;
            sum.method_code  = method_next;
            sum.extra_length = xtotal_next;
            sum.header_crc   = hcheck_next;
            if (phase_next != gzhp_pkg::PH_BODY ||
                fill_next < gzhp_pkg::FILL_BITS'(gzhp_pkg::TAIL_DEPTH)) begin
                sum.status = gzhp_pkg::ST_TRUNCATED;
            end else begin
                sum.data_crc   = {tail_next[3], tail_next[2], tail_next[1], tail_next[0]};
                sum.input_size = {tail_next[7], tail_next[6], tail_next[5], tail_next[4]};
                sum.payload_length = (count_ext[63:32] != 32'h0) ? 32'hffff_ffff
                                                                 : count_ext[31:0];
                sum.status = (method_next == gzhp_pkg::METHOD_DEFLATE && count_next != '0) ?
                             gzhp_pkg::ST_OK : gzhp_pkg::ST_NOT_DEFLATE;
            end
        end
    end

    assign push = accept && (has_pay || final_byte);
    assign push_entry.has_payload  = has_pay;
    assign push_entry.payload_byte = pay_byte;
    assign push_entry.has_summary  = final_byte;
    assign push_entry.summary      = sum;

    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && final_byte)) begin
            phase_reg  <= gzhp_pkg::PH_FIXED;
            hpos_reg   <= 4'd0;
            magic_reg  <= 1'b1;
            method_reg <= 8'h00;
            flags_reg  <= 8'h00;
            xtotal_reg <= 16'h0000;
            xleft_reg  <= 16'h0000;
            hcheck_reg <= 16'h0000;
            fill_reg   <= '0;
            total_reg  <= 5'd0;
            count_reg  <= '0;
        end else if (accept) begin
            phase_reg  <= phase_next;
            hpos_reg   <= hpos_next;
            magic_reg  <= magic_next;
            method_reg <= method_next;
            flags_reg  <= flags_next;
            xtotal_reg <= xtotal_next;
            xleft_reg  <= xleft_next;
            hcheck_reg <= hcheck_next;
            fill_reg   <= fill_next;
            total_reg  <= total_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) tail_reg <= tail_next;
    end

endmodule

// ===== hdl/gzhp_queue.sv =====
module gzhp_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  gzhp_pkg::entry_t push_entry,
    output logic             full,
    input  logic             pop,
    output logic             q_valid,
    output gzhp_pkg::entry_t q_entry
);

    localparam int PTR_BITS = $clog2(gzhp_pkg::QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(gzhp_pkg::QUEUE_DEPTH + 1);

    gzhp_pkg::entry_t mem [gzhp_pkg::QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_BITS-1:0] count_reg;

    assign full    = (count_reg == CNT_BITS'(gzhp_pkg::QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_entry = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) mem[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + PTR_BITS'(1);
            if (pop) rd_ptr_reg <= rd_ptr_reg + PTR_BITS'(1);
            if (push && !pop) count_reg <= count_reg + CNT_BITS'(1);
            else if (pop && !push) count_reg <= count_reg - CNT_BITS'(1);
        end
    end

endmodule

// ===== hdl/gzhp_back.sv =====
module gzhp_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    input  gzhp_pkg::entry_t q_entry,
    output logic             pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [159:0]     m_tdata,
    output logic             m_tuser
);

    logic               valid_reg, valid_next;
    logic               kind_reg, kind_next;
    logic [7:0]         pay_reg, pay_next;
    gzhp_pkg::summary_t sum_reg, sum_next;
    logic               pend_reg, pend_next;
    gzhp_pkg::summary_t pend_sum_reg, pend_sum_next;
    logic               out_free;

    assign out_free = !valid_reg || m_tready;
    assign pop = out_free && !pend_reg && q_valid;

    always_comb begin
        valid_next    = valid_reg;
        kind_next     = kind_reg;
        pay_next      = pay_reg;
        sum_next      = sum_reg;
        pend_next     = pend_reg;
        pend_sum_next = pend_sum_reg;
        if (out_free) begin
            if (pend_reg) begin
                // summary that followed a payload byte of the same input
                valid_next = 1'b1;
                kind_next  = gzhp_pkg::KIND_SUMMARY;
                pay_next   = 8'h00;
                sum_next   = pend_sum_reg;
                pend_next  = 1'b0;
            end else if (q_valid) begin
                valid_next = 1'b1;
                if (q_entry.has_payload) begin
                    kind_next     = gzhp_pkg::KIND_PAYLOAD;
                    pay_next      = q_entry.payload_byte;
                    sum_next      = '0;
                    pend_next     = q_entry.has_summary;
                    pend_sum_next = q_entry.summary;
                end else begin
                    kind_next = gzhp_pkg::KIND_SUMMARY;
                    pay_next  = 8'h00;
                    sum_next  = q_entry.summary;
                end
            end else begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg     <= kind_next;
        pay_reg      <= pay_next;
        sum_reg      <= sum_next;
        pend_sum_reg <= pend_sum_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = {5'b00000, sum_reg.header_crc, sum_reg.extra_length,
                       sum_reg.payload_length, sum_reg.input_size, sum_reg.data_crc,
                       sum_reg.method_code, sum_reg.header_flags, sum_reg.status, pay_reg};

    a_pend_has_output: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> valid_reg)
        else $error("pending summary without a shown payload byte");

    a_pend_after_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(pend_reg) |-> (kind_reg == gzhp_pkg::KIND_PAYLOAD))
        else $error("summary held back behind something other than a payload byte");

    a_no_pop_while_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> !pop)
        else $error("queue read while a summary is still pending");

    a_payload_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && kind_reg == gzhp_pkg::KIND_PAYLOAD) |-> (sum_reg == '0))
        else $error("payload transaction carries summary fields");

endmodule

// ===== hdl/gzip_member_header_parser.sv =====
// channel   | dir | tdata (low bit up)                          | tuser | tlast
// s_ input  | in  | data_byte                                   | -     | final_byte
// m_ result | out | payload_byte, status, header_flags,         | kind  | -
//           |     | method_code, data_crc, input_size,          |       |
//           |     | payload_length, extra_length, header_crc    |       |
// one byte is taken per clock while s_tready is high; header parsing and the trailer delay line
// finish in that cycle; results leave one per clock while m_tready is high, through the queue
// and the output register; a last byte that also releases a payload byte gives two results
// a 4-entry queue sits between parser and output register; s_tready drops only when it is full
// aresetn is synchronous, active low; the parser also returns to its reset state after each last byte
module gzip_member_header_parser #(
    parameter int COUNT_BITS = gzhp_pkg::COUNT_BITS
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [159:0] m_tdata,   // payload_byte, status, header_flags, method_code, data_crc,
                                    // input_size, payload_length, extra_length, header_crc
    output logic         m_tuser    // [0] kind
);

    logic             accept;
    logic             push;
    gzhp_pkg::entry_t push_entry;
    logic             full;
    logic             pop;
    logic             q_valid;
    gzhp_pkg::entry_t q_entry;

    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    gzhp_front #(
        .COUNT_BITS(COUNT_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .data_byte  (s_tdata),
        .final_byte (s_tlast),
        .push       (push),
        .push_entry (push_entry)
    );

    gzhp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .q_valid    (q_valid),
        .q_entry    (q_entry)
    );

    gzhp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_entry  (q_entry),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
